// ===== rtl/ntbtx_pkg.sv =====
// ----------------------------------------------------------------------------
// NTB16 TX header builder package
// Shared widths, header constants, codes, FSM state and inter-module structs.
// ----------------------------------------------------------------------------
package ntbtx_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 1514;

  localparam int HW_W      = 16;  // halfword / register width
  localparam int CFG_IDX_W = 8;   // configuration register index width
  localparam int DVD_W     = 17;  // remainder unit dividend width (NDP end offset)
  localparam int LAY_W     = 19;  // layout arithmetic width (offsets before range check)
  localparam int IDX_W     = 4;   // halfword index width
  localparam int NUM_HW    = 14;  // header halfwords per block

  localparam logic [31:0] NTH_SIG = 32'h484D_434E;
  localparam logic [31:0] NDP_SIG = 32'h304D_434E;

  localparam logic [HW_W-1:0] NTH_LEN       = 16'd12;
  localparam logic [HW_W-1:0] NDP_HDR_LEN   = 16'd8;
  localparam logic [HW_W-1:0] NDP_ENTRY_LEN = 16'd4;
  localparam logic [HW_W-1:0] NDP_LEN       = NDP_HDR_LEN + 16'(2 * NDP_ENTRY_LEN);
  localparam logic [HW_W-1:0] MIN_FRAME     = 16'd14;
  localparam logic [HW_W-1:0] WIRE_MAX      = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NTB_MAX_SIZE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NDP_ALIGNMENT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_DIVISOR   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_REMAINDER = 8'd3;

  localparam logic [HW_W-1:0] RST_NTB_MAX_SIZE      = 16'd2048;
  localparam logic [HW_W-1:0] RST_NDP_ALIGNMENT     = 16'd4;
  localparam logic [HW_W-1:0] RST_PAYLOAD_DIVISOR   = 16'd4;
  localparam logic [HW_W-1:0] RST_PAYLOAD_REMAINDER = 16'd0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CFG_ZERO = 2'd1,
    ST_REJECT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_CALC,
    S_CHECK,
    S_EMIT,
    S_ERR
  } state_t;

  // Request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [HW_W-1:0]  divisor;
  } div_req_t;

  // Response from the remainder unit
  typedef struct packed {
    logic            done;
    logic [HW_W-1:0] rem;
  } div_rsp_t;

  // Layout values of the block being emitted
  typedef struct packed {
    logic [HW_W-1:0] ndp;
    logic [HW_W-1:0] dgo;
    logic [HW_W-1:0] blk;
    logic [HW_W-1:0] seq;
    logic [HW_W-1:0] flen;
  } hdr_t;

endpackage

// ===== rtl/ntbtx_ifs.sv =====
// ----------------------------------------------------------------------------
// NTB16 TX header builder channel interfaces
// Valid/ready channels for frame lengths, header results and register writes.
// ----------------------------------------------------------------------------
interface ntbtx_in_if import ntbtx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [HW_W-1:0] frame_length;

  modport source (output valid, output frame_length, input ready);
  modport sink (input valid, input frame_length, output ready);
endinterface

interface ntbtx_out_if import ntbtx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [HW_W-1:0] byte_offset;
  logic [HW_W-1:0] half_word;
  logic [HW_W-1:0] ndp_offset;
  logic [HW_W-1:0] datagram_offset;
  logic [HW_W-1:0] block_length;
  logic [HW_W-1:0] seq_number;
  logic            last;

  modport source (
    output valid, output status, output byte_offset, output half_word,
    output ndp_offset, output datagram_offset, output block_length,
    output seq_number, output last, input ready
  );
  modport sink (
    input valid, input status, input byte_offset, input half_word,
    input ndp_offset, input datagram_offset, input block_length,
    input seq_number, input last, output ready
  );
endinterface

interface ntbtx_cfg_if import ntbtx_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [HW_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ntbtx_rem.sv =====
// ----------------------------------------------------------------------------
// NTB16 TX remainder unit
// Restoring bit-serial modulo: one dividend bit per cycle, one shared subtractor.
// ----------------------------------------------------------------------------
module ntbtx_rem import ntbtx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [HW_W-1:0]  dsr_r, dsr_nxt;
  logic [HW_W-1:0]  rem_r, rem_nxt;

  logic [HW_W:0]    trial;
  logic             fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? HW_W'(trial - {1'b0, dsr_r}) : trial[HW_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/ntbtx_emit.sv =====
// ----------------------------------------------------------------------------
// NTB16 TX header halfword selector
// Maps a halfword index to its NTH16/NDP16 value and byte position.
// ----------------------------------------------------------------------------
module ntbtx_emit import ntbtx_pkg::*; (
  input  hdr_t             hdr,
  input  logic [IDX_W-1:0] idx,
  output logic [HW_W-1:0]  byte_offset,
  output logic [HW_W-1:0]  half_word
);

  always_comb begin
    unique case (idx)
      4'd0: begin
        byte_offset = 16'd0;
        half_word   = NTH_SIG[15:0];
      end
      4'd1: begin
        byte_offset = 16'd2;
        half_word   = NTH_SIG[31:16];
      end
      4'd2: begin
        byte_offset = 16'd4;
        half_word   = NTH_LEN;
      end
      4'd3: begin
        byte_offset = 16'd6;
        half_word   = hdr.seq;
      end
      4'd4: begin
        byte_offset = 16'd8;
        half_word   = hdr.blk;
      end
      4'd5: begin
        byte_offset = 16'd10;
        half_word   = hdr.ndp;
      end
      4'd6: begin
        byte_offset = hdr.ndp;
        half_word   = NDP_SIG[15:0];
      end
      4'd7: begin
        byte_offset = hdr.ndp + 16'd2;
        half_word   = NDP_SIG[31:16];
      end
      4'd8: begin
        byte_offset = hdr.ndp + 16'd4;
        half_word   = NDP_LEN;
      end
      4'd9: begin
        byte_offset = hdr.ndp + 16'd6;
        half_word   = 16'd0;
      end
      4'd10: begin
        byte_offset = hdr.ndp + 16'd8;
        half_word   = hdr.dgo;
      end
      4'd11: begin
        byte_offset = hdr.ndp + 16'd10;
        half_word   = hdr.flen;
      end
      4'd12: begin
        byte_offset = hdr.ndp + 16'd12;
        half_word   = 16'd0;
      end
      4'd13: begin
        byte_offset = hdr.ndp + 16'd14;
        half_word   = 16'd0;
      end
      default: begin
        byte_offset = 16'd0;
        half_word   = 16'd0;
      end
    endcase
  end

endmodule

// ===== rtl/ncm_ntb16_tx_header_builder_top.sv =====
// ----------------------------------------------------------------------------
// NCM NTB16 TX header builder
// Per frame length, lays out one single-datagram NTB16 and streams its header.
// ----------------------------------------------------------------------------
// Each frame length transfer on in_s yields either fourteen header halfwords
// (NTH16 at byte 0, then an NDP16 with one entry and a zero terminator), each
// with its byte position and the block's layout values, or a single status
// result when the configuration holds a zero or the frame/layout is rejected.
// The block takes one frame at a time: in_s.ready is high only while idle.
// A frame that passes steps through load, the serial remainder unit (one bit
// of the NDP end offset per cycle), offset calc and layout check, then makes
// the fourteen output transfers; only after the last one is the next frame
// taken. A configuration or length error goes from load straight to its
// status result, a layout error from the layout check. A stall on out_m
// holds the current result and delays all that follow. Registers are to be
// written through cfg_s only while the block is idle; the block itself does
// not enforce this. cfg_s.ready is always high and writes to an unknown
// index are dropped. The sequence number advances only on frames that pass,
// so the first good frame after reset carries 1.
// ----------------------------------------------------------------------------
module ncm_ntb16_tx_header_builder_top import ntbtx_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ntbtx_cfg_if.sink     cfg_s,
  ntbtx_in_if.sink      in_s,
  ntbtx_out_if.source   out_m
);

  localparam logic [HW_W-1:0] MaxFrame = HW_W'(MAX_FRAME_BYTES);

  // configuration registers
  logic [HW_W-1:0] max_size_r;
  logic [HW_W-1:0] align_r;
  logic [HW_W-1:0] divisor_r;
  logic [HW_W-1:0] remainder_r;

  // per-frame working state
  state_t           state_r, state_nxt;
  logic [HW_W-1:0]  flen_r;
  logic [DVD_W-1:0] ndp_r, ndp_nxt;
  logic [LAY_W-1:0] dgo_r, dgo_nxt;
  logic [LAY_W-1:0] blk_r, blk_nxt;
  logic [HW_W-1:0]  seq_r, seq_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  status_t          err_r, err_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;
  hdr_t     hdr;

  logic             cfg_zero;
  logic             len_bad;
  logic [DVD_W-1:0] ndp_calc;
  logic [DVD_W-1:0] base;
  logic [LAY_W-1:0] gap;
  logic [LAY_W-1:0] blk_calc;
  logic             layout_bad;
  logic             out_xfer;
  logic [HW_W-1:0]  emit_offset;
  logic [HW_W-1:0]  emit_half;

  // --------------------------------------------------------------------------
  // Register writes
  // --------------------------------------------------------------------------
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r  <= RST_NTB_MAX_SIZE;
      align_r     <= RST_NDP_ALIGNMENT;
      divisor_r   <= RST_PAYLOAD_DIVISOR;
      remainder_r <= RST_PAYLOAD_REMAINDER;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        CFG_NTB_MAX_SIZE:      max_size_r  <= cfg_s.data;
        CFG_NDP_ALIGNMENT:     align_r     <= cfg_s.data;
        CFG_PAYLOAD_DIVISOR:   divisor_r   <= cfg_s.data;
        CFG_PAYLOAD_REMAINDER: remainder_r <= cfg_s.data;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Layout arithmetic
  // --------------------------------------------------------------------------
  assign cfg_zero = (max_size_r == '0) || (divisor_r == '0) || (align_r == '0);
  assign len_bad  = (flen_r < MIN_FRAME) || (flen_r > MaxFrame);

  // Round 12 up to the alignment; the mask keeps every bit above the 16-bit
  // register set, so an alignment that is not a power of two passes as is.
  assign ndp_calc = ({1'b0, align_r} + DVD_W'(NTH_LEN - 16'd1))
                    & {1'b1, ~(align_r - 16'd1)};
  assign base     = ndp_r + DVD_W'(NDP_LEN);

  // Distance from the NDP end to the next offset with the wanted remainder
  assign gap = (div_rsp.rem <= remainder_r)
             ? LAY_W'(remainder_r - div_rsp.rem)
             : LAY_W'(divisor_r - div_rsp.rem) + LAY_W'(remainder_r);

  assign blk_calc   = dgo_r + LAY_W'(flen_r);
  assign layout_bad = (ndp_r > DVD_W'(WIRE_MAX)) || (dgo_r > LAY_W'(WIRE_MAX))
                   || (blk_calc > LAY_W'(WIRE_MAX)) || (blk_calc > LAY_W'(max_size_r));

  ntbtx_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  assign out_xfer = out_m.valid && out_m.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_s.valid) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = (cfg_zero || len_bad) ? S_ERR : S_DIV;
      S_DIV:   if (div_rsp.done) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = layout_bad ? S_ERR : S_EMIT;
      S_EMIT:  if (out_xfer && idx_r == IDX_W'(NUM_HW - 1)) state_nxt = S_IDLE;
      S_ERR:   if (out_xfer) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath controls
  // --------------------------------------------------------------------------
  always_comb begin
    ndp_nxt          = ndp_r;
    dgo_nxt          = dgo_r;
    blk_nxt          = blk_r;
    seq_nxt          = seq_r;
    idx_nxt          = idx_r;
    err_nxt          = err_r;
    div_req.start    = 1'b0;
    div_req.dividend = ndp_calc + DVD_W'(NDP_LEN);
    div_req.divisor  = divisor_r;
    unique case (state_r)
      S_LOAD: begin
        // config check ranks ahead of the length check
        ndp_nxt = ndp_calc;
        if (cfg_zero) begin
          err_nxt = ST_CFG_ZERO;
        end else if (len_bad) begin
          err_nxt = ST_REJECT;
        end else begin
          div_req.start = 1'b1;
        end
      end
      S_CALC: begin
        dgo_nxt = LAY_W'(base) + gap;
      end
      S_CHECK: begin
        blk_nxt = blk_calc;
        idx_nxt = '0;
        if (layout_bad) begin
          err_nxt = ST_REJECT;
        end else begin
          seq_nxt = seq_r + 16'd1;
        end
      end
      S_EMIT: begin
        if (out_xfer) idx_nxt = idx_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seq_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      seq_r   <= seq_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // hold the frame length and layout for the whole emission
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_s.valid) flen_r <= in_s.frame_length;
    ndp_r <= ndp_nxt;
    dgo_r <= dgo_nxt;
    blk_r <= blk_nxt;
    err_r <= err_nxt;
  end

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  assign hdr.ndp  = ndp_r[HW_W-1:0];
  assign hdr.dgo  = dgo_r[HW_W-1:0];
  assign hdr.blk  = blk_r[HW_W-1:0];
  assign hdr.seq  = seq_r;
  assign hdr.flen = flen_r;

  ntbtx_emit u_emit (
    .hdr         (hdr),
    .idx         (idx_r),
    .byte_offset (emit_offset),
    .half_word   (emit_half)
  );

  assign in_s.ready = (state_r == S_IDLE);

  always_comb begin
    out_m.valid           = 1'b0;
    out_m.status          = ST_OK;
    out_m.byte_offset     = '0;
    out_m.half_word       = '0;
    out_m.ndp_offset      = '0;
    out_m.datagram_offset = '0;
    out_m.block_length    = '0;
    out_m.seq_number      = '0;
    out_m.last            = 1'b0;
    unique case (state_r)
      S_EMIT: begin
        out_m.valid           = 1'b1;
        out_m.byte_offset     = emit_offset;
        out_m.half_word       = emit_half;
        out_m.ndp_offset      = hdr.ndp;
        out_m.datagram_offset = hdr.dgo;
        out_m.block_length    = hdr.blk;
        out_m.seq_number      = hdr.seq;
        out_m.last            = (idx_r == IDX_W'(NUM_HW - 1));
      end
      S_ERR: begin
        // error result carries only the status
        out_m.valid  = 1'b1;
        out_m.status = err_r;
        out_m.last   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/ntbtx_chk.sv =====
// ----------------------------------------------------------------------------
// NTB16 TX header builder port checker
// Watches the top-level ports for result shape and channel ordering.
// ----------------------------------------------------------------------------
module ntbtx_chk import ntbtx_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [1:0]      out_status,
  input logic [HW_W-1:0] out_byte_offset,
  input logic [HW_W-1:0] out_half_word,
  input logic [HW_W-1:0] out_ndp_offset,
  input logic [HW_W-1:0] out_datagram_offset,
  input logic [HW_W-1:0] out_block_length,
  input logic [HW_W-1:0] out_seq_number,
  input logic            out_last
);

  // no new frame while results of the current one are pending
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("frame accepted while results pending");

  // an error result is a lone, zeroed status item
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_last && out_byte_offset == '0 && out_half_word == '0 &&
       out_seq_number == '0 && out_block_length == '0))
    else $error("malformed error result");

  // the NDP terminator closes the block, and the payload follows the headers
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && out_last) |->
      (out_byte_offset == out_ndp_offset + 16'd14 &&
       out_block_length > out_datagram_offset &&
       out_datagram_offset >= out_ndp_offset + 16'd16))
    else $error("final halfword misplaced");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_half_word) && $stable(out_byte_offset) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind ncm_ntb16_tx_header_builder_top ntbtx_chk u_ntbtx_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_s.ready),
  .out_valid           (out_m.valid),
  .out_ready           (out_m.ready),
  .out_status          (out_m.status),
  .out_byte_offset     (out_m.byte_offset),
  .out_half_word       (out_m.half_word),
  .out_ndp_offset      (out_m.ndp_offset),
  .out_datagram_offset (out_m.datagram_offset),
  .out_block_length    (out_m.block_length),
  .out_seq_number      (out_m.seq_number),
  .out_last            (out_m.last)
);

// ===== bench/ntb16_header_checker.sv =====
// ----------------------------------------------------------------------------
// NTB16 header word checker
// Watches the register, frame and header channels of the NTB16 TX header
// builder, predicts each header word or status from its own copy of the
// registers and the sequence counter, and compares every header transfer
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module ntb16_header_checker import ntbtx_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  ntbtx_cfg_if  reg_bus,
  ntbtx_in_if   frame_bus,
  ntbtx_out_if  hdr_bus,
  output int    mismatch_count,
  output int    words_pending
);

  typedef struct packed {
    status_t         status;
    logic [HW_W-1:0] byte_offset;
    logic [HW_W-1:0] half_word;
    logic [HW_W-1:0] ndp_offset;
    logic [HW_W-1:0] datagram_offset;
    logic [HW_W-1:0] block_length;
    logic [HW_W-1:0] seq_number;
    logic            last;
  } hdr_word_t;

  hdr_word_t       header_words_due[$];
  logic [HW_W-1:0] blk_limit;
  logic [HW_W-1:0] ndp_align;
  logic [HW_W-1:0] dg_divisor;
  logic [HW_W-1:0] dg_remainder;
  logic [HW_W-1:0] seq_count;
  int              errs = 0;
  int              due_cnt = 0;

  assign mismatch_count = errs;
  assign words_pending  = due_cnt;

  function automatic string fmt_word(input hdr_word_t w);
    return $sformatf("st=%0d off=%h hw=%h ndp=%h dgo=%h blk=%h seq=%h last=%b",
                     w.status, w.byte_offset, w.half_word, w.ndp_offset,
                     w.datagram_offset, w.block_length, w.seq_number, w.last);
  endfunction

  task automatic queue_word(input status_t st, input logic [31:0] off, hw, ndp, dgo,
                            blk, seq, input logic lst);
    hdr_word_t w;
    w.status          = st;
    w.byte_offset     = off[HW_W-1:0];
    w.half_word       = hw[HW_W-1:0];
    w.ndp_offset      = ndp[HW_W-1:0];
    w.datagram_offset = dgo[HW_W-1:0];
    w.block_length    = blk[HW_W-1:0];
    w.seq_number      = seq[HW_W-1:0];
    w.last            = lst;
    header_words_due.push_back(w);
  endtask

  // Lay out one block for this frame length and queue its fourteen words,
  // or the single status word when the frame is refused.
  task automatic build_header_words(input logic [HW_W-1:0] flen);
    logic [31:0] ndp, base, cur, dgo, blk;
    logic [31:0] offs [NUM_HW];
    logic [31:0] vals [NUM_HW];
    int          k;
    if (blk_limit == 0 || dg_divisor == 0 || ndp_align == 0) begin
      queue_word(ST_CFG_ZERO, 0, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    if (flen < MIN_FRAME || 32'(flen) > MAX_FRAME) begin
      queue_word(ST_REJECT, 0, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    // mask form is kept as is for alignments that are not a power of two
    ndp  = (32'(NTH_LEN) + 32'(ndp_align) - 32'd1) & ~(32'(ndp_align) - 32'd1);
    base = ndp + 32'(NDP_LEN);
    cur  = base % 32'(dg_divisor);
    if (cur <= 32'(dg_remainder))
      dgo = base + (32'(dg_remainder) - cur);
    else
      dgo = base + (32'(dg_divisor) - cur) + 32'(dg_remainder);
    blk = dgo + 32'(flen);
    if (ndp > 32'(WIRE_MAX) || dgo > 32'(WIRE_MAX) || blk > 32'(WIRE_MAX) ||
        blk > 32'(blk_limit)) begin
      queue_word(ST_REJECT, 0, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    seq_count = seq_count + 16'd1;
    vals[0]  = 32'(NTH_SIG[15:0]);  offs[0]  = 32'd0;
    vals[1]  = 32'(NTH_SIG[31:16]); offs[1]  = 32'd2;
    vals[2]  = 32'(NTH_LEN);        offs[2]  = 32'd4;
    vals[3]  = 32'(seq_count);      offs[3]  = 32'd6;
    vals[4]  = blk;                 offs[4]  = 32'd8;
    vals[5]  = ndp;                 offs[5]  = 32'd10;
    vals[6]  = 32'(NDP_SIG[15:0]);  offs[6]  = ndp;
    vals[7]  = 32'(NDP_SIG[31:16]); offs[7]  = ndp + 32'd2;
    vals[8]  = 32'(NDP_LEN);        offs[8]  = ndp + 32'd4;
    vals[9]  = 32'd0;               offs[9]  = ndp + 32'd6;
    vals[10] = dgo;                 offs[10] = ndp + 32'd8;
    vals[11] = 32'(flen);           offs[11] = ndp + 32'd10;
    vals[12] = 32'd0;               offs[12] = ndp + 32'd12;
    vals[13] = 32'd0;               offs[13] = ndp + 32'd14;
    for (k = 0; k < NUM_HW; k++)
      queue_word(ST_OK, offs[k], vals[k], ndp, dgo, blk, 32'(seq_count),
                 k == NUM_HW - 1);
  endtask

  always @(posedge clk) begin : watch
    hdr_word_t got;
    hdr_word_t want;
    if (!rst_n) begin
      blk_limit    = RST_NTB_MAX_SIZE;
      ndp_align    = RST_NDP_ALIGNMENT;
      dg_divisor   = RST_PAYLOAD_DIVISOR;
      dg_remainder = RST_PAYLOAD_REMAINDER;
      seq_count    = '0;
      header_words_due.delete();
    end else begin
      if (reg_bus.valid && reg_bus.ready) begin
        case (reg_bus.index)
          CFG_NTB_MAX_SIZE:      blk_limit    = reg_bus.data;
          CFG_NDP_ALIGNMENT:     ndp_align    = reg_bus.data;
          CFG_PAYLOAD_DIVISOR:   dg_divisor   = reg_bus.data;
          CFG_PAYLOAD_REMAINDER: dg_remainder = reg_bus.data;
          default: ;
        endcase
      end
      if (hdr_bus.valid && hdr_bus.ready) begin
        got.status          = status_t'(hdr_bus.status);
        got.byte_offset     = hdr_bus.byte_offset;
        got.half_word       = hdr_bus.half_word;
        got.ndp_offset      = hdr_bus.ndp_offset;
        got.datagram_offset = hdr_bus.datagram_offset;
        got.block_length    = hdr_bus.block_length;
        got.seq_number      = hdr_bus.seq_number;
        got.last            = hdr_bus.last;
        if (header_words_due.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: header word with none due: %s", $time, fmt_word(got));
        end else begin
          want = header_words_due.pop_front();
          if (got != want) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: header word mismatch, expected %s", $time, fmt_word(want));
              $display("%0t:                       actual   %s", $time, fmt_word(got));
            end
          end
        end
      end
      if (frame_bus.valid && frame_bus.ready)
        build_header_words(frame_bus.frame_length);
    end
    due_cnt <= header_words_due.size();
  end

endmodule

// ===== bench/ncm_ntb16_tx_header_builder_top_test.sv =====
// ----------------------------------------------------------------------------
// NCM NTB16 TX header builder testbench
// Drives frame lengths and register settings into the header builder, with
// bursty frame traffic and random and patterned stalls on the header side. A checker
// beside the block predicts every header word and status and counts
// mismatches; this top makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module ncm_ntb16_tx_header_builder_top_test;
  import ntbtx_pkg::*;

  // Random frame transfers after the directed part.
  localparam int RANDOM_FRAMES = 430;
  // Cycles without any transfer before the run is called hung.
  localparam int QUIET_LIMIT   = 4000;
  // Cycles to let the block settle back to idle after its last word.
  localparam int SETTLE_CYCLES = 8;
  // Cycles to wait at the end, about one full block emission.
  localparam int TAIL_CYCLES   = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_PAYLOAD_REMAINDER + 8'd1;

  // Stall styles of the header receiver.
  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_CADENCE
  } sink_mode_t;

  logic clk;
  logic rst_n;
  int   burst_left = 0;
  int   frames_sent = 0;
  int   mismatch_count;
  int   words_pending;

  ntbtx_cfg_if reg_if ();
  ntbtx_in_if  frame_if ();
  ntbtx_out_if hdr_if ();

  ncm_ntb16_tx_header_builder_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (reg_if),
    .in_s  (frame_if),
    .out_m (hdr_if)
  );

  ntb16_header_checker #(
    .MAX_FRAME (MAX_FRAME_BYTES_DEF)
  ) header_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .reg_bus        (reg_if),
    .frame_bus      (frame_if),
    .hdr_bus        (hdr_if),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold the header ready line on one stall style for a random stretch, then
  // switch; the open style gives stretches with no stalls at all.
  initial begin : hdr_sink
    sink_mode_t mode;
    int         span;
    int         tick;
    hdr_if.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(40, 240);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          SINK_OPEN:   hdr_if.ready <= 1'b1;
          SINK_COIN:   hdr_if.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: hdr_if.ready <= ($urandom_range(0, 3) == 0);
          default:     hdr_if.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // Count cycles in which nothing moves on any channel; give up at the limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (frame_if.valid && frame_if.ready) || (hdr_if.valid && hdr_if.ready) ||
          (reg_if.valid && reg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ncm_ntb16_tx_header_builder_top_test: done, errors");
    $finish;
  end

  // Write one register; valid stays high so back-to-back writes need no
  // lowering in between.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HW_W-1:0] val);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= val;
    @(posedge clk);
    while (!reg_if.ready) @(posedge clk);
  endtask

  // Load all four registers while the block is idle. Now and then also hit an
  // unmapped index, which the block must drop.
  task automatic load_regs(input logic [HW_W-1:0] max_size, align, divisor, remainder);
    put_reg(CFG_NTB_MAX_SIZE, max_size);
    put_reg(CFG_NDP_ALIGNMENT, align);
    put_reg(CFG_PAYLOAD_DIVISOR, divisor);
    put_reg(CFG_PAYLOAD_REMAINDER, remainder);
    if ($urandom_range(0, 2) == 0)
      put_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, 255)), HW_W'($urandom));
    reg_if.valid <= 1'b0;
  endtask

  // Offer one frame length. At the start of half the bursts drop valid for a
  // random gap: mostly short, sometimes long enough to land on the idle phase.
  task automatic send_frame(input logic [HW_W-1:0] flen);
    int gap;
    int pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        gap = 0;
      else if (pick < 8)
        gap = $urandom_range(1, 8);
      else
        gap = $urandom_range(20, 60);
      if (gap > 0) begin
        frame_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    frame_if.valid        <= 1'b1;
    frame_if.frame_length <= flen;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
    burst_left--;
    frames_sent++;
  endtask

  // Drop valid and hold off until every predicted word has come back, then
  // let the block settle so the registers can be written safely.
  task automatic drain_frames();
    frame_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed settings that let frames through; the rest is noise,
  // zero registers and remainders at or above the divisor.
  task automatic pick_layout(output logic [HW_W-1:0] max_size, align, divisor, remainder);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      max_size  = HW_W'($urandom);
      align     = HW_W'($urandom);
      divisor   = HW_W'($urandom);
      remainder = HW_W'($urandom);
    end else begin
      max_size  = ($urandom_range(0, 4) == 0) ? HW_W'($urandom_range(28, 1600))
                                              : HW_W'($urandom_range(1700, 65535));
      align     = ($urandom_range(0, 4) == 0) ? HW_W'(1 << $urandom_range(7, 15))
                                              : HW_W'(1 << $urandom_range(0, 6));
      divisor   = ($urandom_range(0, 4) == 0) ? HW_W'($urandom_range(1, 65535))
                                              : HW_W'($urandom_range(1, 16));
      remainder = HW_W'($urandom_range(0, divisor - 1));
      if (pick == 1) begin
        // zero one register so the configuration check fires
        case ($urandom_range(0, 2))
          0:       max_size = '0;
          1:       align    = '0;
          default: divisor  = '0;
        endcase
      end else if (pick == 2) begin
        remainder = HW_W'($urandom_range(divisor, 65535));
      end
    end
  endtask

  // Mostly legal lengths; some below the minimum, some above the maximum,
  // some fully random, and the boundaries.
  function automatic logic [HW_W-1:0] pick_length();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return HW_W'($urandom);
      1:       return HW_W'($urandom_range(0, MIN_FRAME - 1));
      2:       return ($urandom_range(0, 1) == 1) ? MIN_FRAME
                                                  : HW_W'(MAX_FRAME_BYTES_DEF);
      3:       return HW_W'(MAX_FRAME_BYTES_DEF + 1);
      default: return HW_W'($urandom_range(MIN_FRAME, MAX_FRAME_BYTES_DEF));
    endcase
  endfunction

  initial begin : stimulus
    logic [HW_W-1:0] max_size, align, divisor, remainder;
    int              span;
    int              k;

    // Drive every input to a known value before the first edge.
    rst_n                 <= 1'b0;
    frame_if.valid        <= 1'b0;
    frame_if.frame_length <= '0;
    reg_if.valid          <= 1'b0;
    reg_if.index          <= '0;
    reg_if.data           <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: length extremes and alternating bit patterns.
    send_frame(MIN_FRAME);
    send_frame(HW_W'(MAX_FRAME_BYTES_DEF));
    send_frame(MIN_FRAME - 16'd1);
    send_frame(16'd0);
    send_frame(HW_W'(MAX_FRAME_BYTES_DEF + 1));
    send_frame(16'hFFFF);
    send_frame(16'h5555);
    send_frame(16'hAAAA);
    send_frame(16'd64);
    drain_frames();

    // Each zero register alone gives the configuration status.
    load_regs(16'd0, 16'd4, 16'd4, 16'd0);
    send_frame(16'd64);
    send_frame(16'd3);
    drain_frames();
    load_regs(16'd2048, 16'd0, 16'd4, 16'd0);
    send_frame(16'd64);
    drain_frames();
    load_regs(16'd2048, 16'd4, 16'd0, 16'd0);
    send_frame(16'd64);
    drain_frames();

    // Register maxima: layout runs past 16 bits, and a non-power-of-two
    // alignment pushes the NDP offset out of range.
    load_regs(16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFE);
    send_frame(MIN_FRAME);
    drain_frames();
    load_regs(16'hFFFF, 16'hFFFF, 16'd1, 16'd0);
    send_frame(MIN_FRAME);
    drain_frames();

    // Block length exactly at the negotiated maximum, then one byte over.
    load_regs(16'd42, 16'd4, 16'd4, 16'd0);
    send_frame(MIN_FRAME);
    send_frame(MIN_FRAME + 16'd1);
    drain_frames();

    // Odd alignment with remainder above the divisor, then a remainder that
    // forces the wrap to the next multiple.
    load_regs(16'd2048, 16'd6, 16'd7, 16'd10);
    send_frame(16'd60);
    drain_frames();
    load_regs(16'd2048, 16'd4, 16'd5, 16'd1);
    send_frame(16'd60);
    drain_frames();
    load_regs(16'hFFFF, 16'd1, 16'd1, 16'd0);
    send_frame(HW_W'(MAX_FRAME_BYTES_DEF));
    drain_frames();

    // Random phases: new settings, then a run of frame lengths.
    frames_sent = 0;
    while (frames_sent < RANDOM_FRAMES) begin
      pick_layout(max_size, align, divisor, remainder);
      load_regs(max_size, align, divisor, remainder);
      span = $urandom_range(20, 50);
      for (k = 0; k < span; k++)
        send_frame(pick_length());
      drain_frames();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0)
      $display("ncm_ntb16_tx_header_builder_top_test: done, clean");
    else
      $display("ncm_ntb16_tx_header_builder_top_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ntbtx_pkg.sv
rtl/ntbtx_ifs.sv
rtl/ntbtx_rem.sv
rtl/ntbtx_emit.sv
rtl/ncm_ntb16_tx_header_builder_top.sv
rtl/ntbtx_chk.sv
bench/ntb16_header_checker.sv
bench/ncm_ntb16_tx_header_builder_top_test.sv
